/* sv/tun_pkg.sv */
// shared widths and types for the triangle unit normal pipeline
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
    localparam int CW    = 16;            // coordinate width
    localparam int F     = 14;            // normal fraction bits
    localparam int EW    = CW + 1;        // edge width
    localparam int PW    = 2 * EW;        // product width, also cross magnitude width
    localparam int XW    = PW + 1;        // signed cross component width
    localparam int SW    = 2 * PW + 2;    // sum of squares width
    localparam int XWID  = SW + 2 * F;    // radicand width
    localparam int RW    = XWID / 2;      // root width
    localparam int REMW  = RW + 3;        // root remainder width
    localparam int NW    = PW + 2 * F;    // dividend width
    localparam int QB    = F + 2;         // quotient bits
    localparam int R0W   = NW - QB;       // dividend bits above the quotient
    localparam int OW    = F + 2;         // output width

    typedef struct packed {
        logic [PW-1:0] mx;
        logic [PW-1:0] my;
        logic [PW-1:0] mz;
        logic [2:0]    neg;
        logic          degen;
    } t_side;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_sign;
endpackage
`default_nettype wire

/* sv/triangle_unit_normal.sv */
// triangle face unit normal: edges, cross product, root and three divides
// pipeline: 72 register stages (6 front stages, 49 square root stages, 16 divide stages,
//   1 output register)
// throughput: one triangle per cycle, busy stays low, set by the bit-per-stage root and divide
// the receiver cannot stall, so every result leaves on its strobe cycle
// reset clears all valid bits; no result strobes until new words enter
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal
    import tun_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [CW-1:0] i_ax,
    input  wire logic signed [CW-1:0] i_ay,
    input  wire logic signed [CW-1:0] i_az,
    input  wire logic signed [CW-1:0] i_bx,
    input  wire logic signed [CW-1:0] i_by_coord,
    input  wire logic signed [CW-1:0] i_bz,
    input  wire logic signed [CW-1:0] i_cx,
    input  wire logic signed [CW-1:0] i_cy,
    input  wire logic signed [CW-1:0] i_cz,
    output logic                      o_valid,
    output logic signed [OW-1:0]      o_nx,
    output logic signed [OW-1:0]      o_ny,
    output logic signed [OW-1:0]      o_nz,
    output logic                      o_degenerate
);
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [EW-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [XW-1:0] r_crx, r_cry, r_crz;
    logic [PW-1:0]        r_mx, r_my, r_mz;
    logic [2:0]           r_neg4, r_neg5, r_neg6;
    logic [2*PW-1:0]      r_sqx, r_sqy, r_sqz;
    logic [PW-1:0]        r_mx5, r_my5, r_mz5, r_mx6, r_my6, r_mz6;
    logic [SW-1:0]        r_s;
    t_side                r_d1 [RW];
    t_sign                r_d2 [QB];
    t_side                side6;
    logic                 sq_valid;
    logic [RW-1:0]        root;
    logic                 dv_x, dv_y, dv_z;
    logic [QB-1:0]        q_x, q_y, q_z;
    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
        r_e1x <= EW'(i_ax) - EW'(i_bx);
        r_e1y <= EW'(i_ay) - EW'(i_by_coord);
        r_e1z <= EW'(i_az) - EW'(i_bz);
        r_e2x <= EW'(i_bx) - EW'(i_cx);
        r_e2y <= EW'(i_by_coord) - EW'(i_cy);
        r_e2z <= EW'(i_bz) - EW'(i_cz);
        r_p0  <= r_e1y * r_e2z;
        r_p1  <= r_e1z * r_e2y;
        r_p2  <= r_e1z * r_e2x;
        r_p3  <= r_e1x * r_e2z;
        r_p4  <= r_e1x * r_e2y;
        r_p5  <= r_e1y * r_e2x;
        r_crx <= XW'(r_p0) - XW'(r_p1);
        r_cry <= XW'(r_p2) - XW'(r_p3);
        r_crz <= XW'(r_p4) - XW'(r_p5);
        r_neg4 <= {r_crz[XW-1], r_cry[XW-1], r_crx[XW-1]};
        r_mx  <= PW'(r_crx[XW-1] ? -r_crx : r_crx);
        r_my  <= PW'(r_cry[XW-1] ? -r_cry : r_cry);
        r_mz  <= PW'(r_crz[XW-1] ? -r_crz : r_crz);
        r_sqx <= r_mx * r_mx;
        r_sqy <= r_my * r_my;
        r_sqz <= r_mz * r_mz;
        r_mx5 <= r_mx;
        r_my5 <= r_my;
        r_mz5 <= r_mz;
        r_neg5 <= r_neg4;
        r_s   <= SW'(r_sqx) + SW'(r_sqy) + SW'(r_sqz);
        r_mx6 <= r_mx5;
        r_my6 <= r_my5;
        r_mz6 <= r_mz5;
        r_neg6 <= r_neg5;
    end

    always_comb begin
        side6.mx    = r_mx6;
        side6.my    = r_my6;
        side6.mz    = r_mz6;
        side6.neg   = r_neg6;
        side6.degen = (r_s == '0);
    end

    tun_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_x     ({r_s, {(2*F){1'b0}}}),
        .o_valid (sq_valid),
        .o_root  (root)
    );

    // sideband delay lines run alongside the root and divide stages
    always_ff @(posedge i_clk) begin
        r_d1[0] <= side6;
        for (int k = 1; k < RW; k++) begin
            r_d1[k] <= r_d1[k-1];
        end
        r_d2[0].neg   <= r_d1[RW-1].neg;
        r_d2[0].degen <= r_d1[RW-1].degen;
        for (int k = 1; k < QB; k++) begin
            r_d2[k] <= r_d2[k-1];
        end
    end

    tun_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   ({r_d1[RW-1].mx, {(2*F){1'b0}}}),
        .i_den   (root),
        .o_valid (dv_x),
        .o_quot  (q_x)
    );

    tun_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   ({r_d1[RW-1].my, {(2*F){1'b0}}}),
        .i_den   (root),
        .o_valid (dv_y),
        .o_quot  (q_y)
    );

    tun_div u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_num   ({r_d1[RW-1].mz, {(2*F){1'b0}}}),
        .i_den   (root),
        .o_valid (dv_z),
        .o_quot  (q_z)
    );

    localparam logic [QB-1:0] LIMIT = QB'(1) << F;

    logic [QB-1:0] sat_x, sat_y, sat_z;
    logic          degen_q;
    t_sign         sgn;

    always_comb begin
        sgn     = r_d2[QB-1];
        degen_q = sgn.degen;
        sat_x   = (q_x > LIMIT) ? LIMIT : q_x;
        sat_y   = (q_y > LIMIT) ? LIMIT : q_y;
        sat_z   = (q_z > LIMIT) ? LIMIT : q_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dv_x;
        end
        o_degenerate <= degen_q;
        o_nx <= degen_q ? '0 : OW'(sgn.neg[0] ? -sat_x : sat_x);
        o_ny <= degen_q ? '0 : OW'(sgn.neg[1] ? -sat_y : sat_y);
        o_nz <= degen_q ? '0 : OW'(sgn.neg[2] ? -sat_z : sat_z);
    end

    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_x == dv_y) && (dv_x == dv_z))
        else $error("divider valid bits out of step");

    a_degen_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_nx == '0 && o_ny == '0 && o_nz == '0))
        else $error("degenerate result with nonzero normal");

    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nx <= $signed(OW'(LIMIT)) && o_nx >= -$signed(OW'(LIMIT))))
        else $error("normal x component out of range");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_valid |-> ##(QB+1) o_valid)
        else $error("result strobe lost after root");
endmodule
`default_nettype wire

/* sv/tun_isqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tun_isqrt
    import tun_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [XWID-1:0] i_x,
    output logic                 o_valid,
    output logic [RW-1:0]        o_root
);
    logic            r_vld  [RW];
    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [XWID-1:0] r_x    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            p_vld;
        logic [REMW-1:0] p_rem;
        logic [RW-1:0]   p_root;
        logic [XWID-1:0] p_x;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;
        logic [REMW-1:0] n_rem;
        logic [RW-1:0]   n_root;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_x;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_x    = r_x[k-1];
        end

        always_comb begin
            rem_sh = {p_rem[REMW-3:0], p_x[XWID-1 -: 2]};
            trial  = {1'b0, p_root, 2'b01};
            ge     = rem_sh >= trial;
            n_rem  = ge ? rem_sh - trial : rem_sh;
            n_root = {p_root[RW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_x[k]    <= {p_x[XWID-3:0], 2'b00};
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
endmodule
`default_nettype wire

/* sv/tun_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module tun_div
    import tun_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [RW-1:0] i_den,
    output logic               o_valid,
    output logic [QB-1:0]      o_quot
);
    logic          r_vld [QB];
    logic [RW-1:0] r_rem [QB];
    logic [RW-1:0] r_den [QB];
    logic [QB-1:0] r_lo  [QB];
    logic [QB-1:0] r_q   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic          p_vld;
        logic [RW-1:0] p_rem;
        logic [RW-1:0] p_den;
        logic [QB-1:0] p_lo;
        logic [QB-1:0] p_q;
        logic [RW:0]   rs;
        logic          ge;
        logic [RW:0]   diff;

        if (k == 0) begin : g_first
            // quotient is known to fit in QB bits, so the top part starts as remainder
            assign p_vld = i_valid;
            assign p_rem = {{(RW-R0W){1'b0}}, i_num[NW-1:QB]};
            assign p_den = i_den;
            assign p_lo  = i_num[QB-1:0];
            assign p_q   = '0;
        end else begin : g_next
            assign p_vld = r_vld[k-1];
            assign p_rem = r_rem[k-1];
            assign p_den = r_den[k-1];
            assign p_lo  = r_lo[k-1];
            assign p_q   = r_q[k-1];
        end

        always_comb begin
            rs   = {p_rem, p_lo[QB-1]};
            ge   = rs >= {1'b0, p_den};
            diff = ge ? rs - {1'b0, p_den} : rs;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rem[k] <= diff[RW-1:0];
            r_den[k] <= p_den;
            r_lo[k]  <= {p_lo[QB-2:0], 1'b0};
            r_q[k]   <= {p_q[QB-2:0], ge};
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_quot  = r_q[QB-1];
endmodule
`default_nettype wire

/* tb/tun_checker.sv */
// checker for the triangle unit normal: predicts each accepted word and compares results
`timescale 1ns / 1ps
`default_nettype none
module tun_checker
    import tun_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic signed [CW-1:0] i_ax,
    input  wire logic signed [CW-1:0] i_ay,
    input  wire logic signed [CW-1:0] i_az,
    input  wire logic signed [CW-1:0] i_bx,
    input  wire logic signed [CW-1:0] i_by_coord,
    input  wire logic signed [CW-1:0] i_bz,
    input  wire logic signed [CW-1:0] i_cx,
    input  wire logic signed [CW-1:0] i_cy,
    input  wire logic signed [CW-1:0] i_cz,
    input  wire logic                 o_valid,
    input  wire logic signed [OW-1:0] o_nx,
    input  wire logic signed [OW-1:0] o_ny,
    input  wire logic signed [OW-1:0] o_nz,
    input  wire logic                 o_degenerate,
    output int                        o_fail_count,
    output int                        o_normals_pending
);
    typedef struct packed {
        logic [OW-1:0] nx;
        logic [OW-1:0] ny;
        logic [OW-1:0] nz;
        logic          degen;
    } t_normal;

    t_normal expected_normals[$];

    initial o_fail_count = 0;
    assign o_normals_pending = expected_normals.size();

    function automatic logic [127:0] magnitude(input longint v);
        return (v < 0) ? 128'(-v) : 128'(v);
    endfunction

    function automatic logic [OW-1:0] scale_component(input longint c, input logic [127:0] root);
        logic [127:0] q;
        logic [OW-1:0] r;
        q = (magnitude(c) << (2 * F)) / root;
        if (q > (128'd1 << F))
            q = 128'd1 << F;
        r = q[OW-1:0];
        return (c < 0) ? -r : r;
    endfunction

    function automatic t_normal unit_normal(
        input logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        longint e1x, e1y, e1z, e2x, e2y, e2z, crx, cry, crz;
        logic [127:0] sum_sq, rad, root, rem, trial;
        t_normal n;
        e1x = longint'(ax) - longint'(bx);
        e1y = longint'(ay) - longint'(by);
        e1z = longint'(az) - longint'(bz);
        e2x = longint'(bx) - longint'(cx);
        e2y = longint'(by) - longint'(cy);
        e2z = longint'(bz) - longint'(cz);
        crx = e1y * e2z - e1z * e2y;
        cry = e1z * e2x - e1x * e2z;
        crz = e1x * e2y - e1y * e2x;
        sum_sq = magnitude(crx) * magnitude(crx) + magnitude(cry) * magnitude(cry)
               + magnitude(crz) * magnitude(crz);
        n = '0;
        if (sum_sq == 0) begin
            n.degen = 1'b1;
            return n;
        end
        rad  = sum_sq << (2 * F);
        root = '0;
        rem  = '0;
        // bit-serial integer square root, two radicand bits per step
        for (int i = 63; i >= 0; i--) begin
            rem   = (rem << 2) | 128'(rad[2*i +: 2]);
            trial = (root << 2) | 128'd1;
            root  = root << 1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = root | 128'd1;
            end
        end
        n.nx = scale_component(crx, root);
        n.ny = scale_component(cry, root);
        n.nz = scale_component(crz, root);
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                   input logic [OW-1:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what,
                 $signed(got), $signed(want));
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && start && !busy)
            expected_normals.push_back(unit_normal(i_ax, i_ay, i_az, i_bx, i_by_coord,
                                                   i_bz, i_cx, i_cy, i_cz));
        if (i_rst_n && o_valid) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected word", '0, '0);
            end else begin
                want = expected_normals.pop_front();
                if (o_nx != want.nx) report_mismatch("nx", o_nx, want.nx);
                if (o_ny != want.ny) report_mismatch("ny", o_ny, want.ny);
                if (o_nz != want.nz) report_mismatch("nz", o_nz, want.nz);
                if (o_degenerate != want.degen)
                    report_mismatch("degenerate", OW'(o_degenerate), OW'(want.degen));
            end
        end
    end
endmodule
`default_nettype wire

/* tb/tb.sv */
// testbench top: drives triangles into the unit normal block and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import tun_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [CW-1:0] i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz;
    logic o_valid;
    logic signed [OW-1:0] o_nx, o_ny, o_nz;
    logic o_degenerate;
    int fail_count;
    int normals_pending;

    triangle_unit_normal dut (.*);

    tun_checker chk (
        .i_clk, .i_rst_n, .start, .busy,
        .i_ax, .i_ay, .i_az, .i_bx, .i_by_coord, .i_bz, .i_cx, .i_cy, .i_cz,
        .o_valid, .o_nx, .o_ny, .o_nz, .o_degenerate,
        .o_fail_count(fail_count), .o_normals_pending(normals_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    bit allow_idle;

    task automatic send_triangle(input logic signed [CW-1:0] ax, ay, az, bx, by, bz,
                                 cx, cy, cz);
        // each cycle idles on its own draw
        while (allow_idle && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_ax <= ax; i_ay <= ay; i_az <= az;
        i_bx <= bx; i_by_coord <= by; i_bz <= bz;
        i_cx <= cx; i_cy <= cy; i_cz <= cz;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic signed [CW-1:0] rand_coord(input bit narrow);
        if (narrow)
            return CW'($signed($urandom_range(0, 64)) - 32);
        return CW'($urandom);
    endfunction

    initial begin
        logic signed [CW-1:0] v[9];
        logic signed [CW-1:0] hi, lo;
        hi = 16'sh7fff;
        lo = 16'sh8000;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_ax, i_ay, i_az, i_bx, i_by_coord, i_bz, i_cx, i_cy, i_cz} = '0;
        allow_idle = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate: all equal, collinear, repeated vertex
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_triangle(hi, hi, hi, lo, lo, lo, 0, 0, 0);
        send_triangle(5, 7, 9, 5, 7, 9, 100, -3, 22);
        send_triangle(1, 2, 3, 2, 4, 6, 3, 6, 9);
        // axis aligned, each sign, exact unit components
        send_triangle(1, 0, 0, 0, 0, 0, 0, 1, 0);
        send_triangle(0, 1, 0, 0, 0, 0, 1, 0, 0);
        send_triangle(0, 0, 1, 0, 0, 0, 1, 0, 0);
        send_triangle(1, 0, 0, 0, 0, 0, 0, 0, 1);
        send_triangle(0, 1, 0, 0, 0, 0, 0, 0, 1);
        send_triangle(0, 0, 1, 0, 0, 0, 0, 1, 0);
        // coordinate extremes, largest edges
        send_triangle(hi, lo, lo, lo, hi, lo, lo, lo, hi);
        send_triangle(lo, hi, hi, hi, lo, hi, hi, hi, lo);
        send_triangle(hi, hi, lo, lo, hi, hi, hi, lo, hi);
        send_triangle(lo, lo, lo, hi, hi, lo, lo, hi, hi);
        send_triangle(hi, 0, 0, 0, hi, 0, 0, 0, hi);
        send_triangle(lo, 0, 0, 0, lo, 0, 0, 0, lo);
        send_triangle(-1, -1, -1, 0, 0, 0, 1, -1, 1);
        send_triangle(hi, hi, hi, hi, hi, lo, hi, lo, lo);

        for (int n = 0; n < 800; n++) begin
            allow_idle = !(n >= 300 && n < 450);
            if (n == 500) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (normals_pending != 0) @(posedge i_clk);
            end
            case ($urandom_range(9))
                0: begin
                    // repeated vertex gives a zero cross product
                    foreach (v[k]) v[k] = rand_coord($urandom_range(1));
                    v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
                end
                1, 2: foreach (v[k]) v[k] = rand_coord(1'b1);
                3: foreach (v[k]) v[k] = $urandom_range(1) ? hi : lo;
                default: foreach (v[k]) v[k] = rand_coord(1'b0);
            endcase
            send_triangle(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
        end
        start <= 1'b0;

        while (normals_pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
sv/tun_pkg.sv
sv/tun_isqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal.sv
tb/tun_checker.sv
tb/tb.sv
